>>> design/bcd_pkg.sv
// shared types and codes for the decimal alu
`timescale 1ns / 1ps
package bcd_pkg;

  localparam logic [2:0] KIND_ADD = 3'd0;
  localparam logic [2:0] KIND_SUB = 3'd1;
  localparam logic [2:0] KIND_MUL = 3'd2;
  localparam logic [2:0] KIND_DIV = 3'd3;
  localparam logic [2:0] KIND_CMP = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_CARRY = 2'd1;
  localparam logic [1:0] ST_UNDER = 2'd2;
  localparam logic [1:0] ST_DIVZ  = 2'd3;

  typedef struct packed {
    logic [2:0]  kind;
    logic [63:0] operand_a;
    logic [63:0] operand_b;
  } in_item_t;

  typedef struct packed {
    logic [63:0] result_value;
    logic        a_less_b;
    logic        a_equal_b;
    logic [1:0]  status;
  } out_item_t;

endpackage

>>> design/bcd_decimal_alu.sv
// top level: sequenced decimal alu around one digit adder
// usage:
//   in channel (in_valid/in_ready, in_data) takes kind and two packed bcd operands
//   out channel (out_valid/out_ready, out_data) gives one result transaction per item
//   work runs one digit per cycle through a single decimal digit adder/subtracter
//   compare/add/subtract: a compare pass over the digits, then one add/subtract pass
//   multiply: shift-and-add, per multiplier digit up to 9 add passes over 2*DIGITS digits
//   divide: restoring, per quotient digit up to 10 trial subtractions over 2*DIGITS
//     digits and one shift step
//   divide by zero ends straight after the compare pass
//   in_ready is low while an item is at work or its result is held unread
//   a stalled receiver holds the result and the block waits
//   rst (synchronous) returns the sequencer to idle and drops any held result
`timescale 1ns / 1ps
module bcd_decimal_alu #(
  parameter int DIGITS = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  bcd_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_ready,
  output bcd_pkg::out_item_t out_data
);
  localparam int W = 2 * DIGITS;
  localparam int IW = $clog2(W);
  localparam int AW = $clog2(DIGITS);

  localparam logic [3:0] S_IDLE = 4'd0;
  localparam logic [3:0] S_CMP  = 4'd1;
  localparam logic [3:0] S_ADD  = 4'd2;
  localparam logic [3:0] S_MCHK = 4'd3;
  localparam logic [3:0] S_MADD = 4'd4;
  localparam logic [3:0] S_DTRY = 4'd5;
  localparam logic [3:0] S_DNXT = 4'd6;
  localparam logic [3:0] S_FIN  = 4'd7;
  localparam logic [3:0] S_OUT  = 4'd8;

  logic [3:0]   state;
  logic [2:0]   kind;
  logic [3:0]   acc [W];   // accumulator / remainder
  logic [3:0]   opx [W];   // shifted addend / divisor
  logic [3:0]   tmp [W];   // trial result
  logic [3:0]   a [DIGITS];
  logic [3:0]   b [DIGITS];
  logic [3:0]   q [DIGITS];
  logic [IW-1:0] idx;
  logic [AW-1:0] pos;
  logic [3:0]   cnt;
  logic         carry;
  logic         lt;
  logic         eq;
  logic         cmp_done;
  logic [1:0]   status;
  logic [3:0]   add_x, add_y, add_s;
  logic         add_sub, add_co;
  logic         bzero;
  logic         mul_hi;

  bcd_adder u_add (
    .x(add_x), .y(add_y), .sub(add_sub), .cin(carry), .sum(add_s), .cout(add_co)
  );

  function automatic logic [3:0] clamp(input logic [3:0] n);
    return (n > 4'd9) ? 4'd9 : n;
  endfunction

  assign in_ready  = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  logic [IW-1:0] cidx;
  assign cidx = IW'(DIGITS - 1) - idx;

  always_comb begin
    add_x = acc[idx];
    add_y = opx[idx];
    add_sub = (state == S_DTRY) || (kind == bcd_pkg::KIND_SUB);
  end

  // divide by zero: divisor all zero digits
  always_comb begin
    bzero = 1'b1;
    for (int i = 0; i < DIGITS; i++) if (b[i] != 4'd0) bzero = 1'b0;
  end

  // product digits above the kept width
  always_comb begin
    mul_hi = 1'b0;
    for (int i = DIGITS; i < W; i++) if (acc[i] != 4'd0) mul_hi = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            kind <= in_data.kind;
            for (int i = 0; i < DIGITS; i++) begin
              a[i] <= clamp(in_data.operand_a[4*i +: 4]);
              b[i] <= clamp(in_data.operand_b[4*i +: 4]);
              q[i] <= 4'd0;
            end
            idx <= '0;
            lt <= 1'b0;
            eq <= 1'b1;
            cmp_done <= 1'b0;
            status <= bcd_pkg::ST_OK;
            state <= S_CMP;
          end
        end
        S_CMP: begin
          // most significant digit first
          if (!cmp_done) begin
            if (a[cidx[AW-1:0]] < b[cidx[AW-1:0]]) begin
              lt <= 1'b1; eq <= 1'b0; cmp_done <= 1'b1;
            end else if (a[cidx[AW-1:0]] > b[cidx[AW-1:0]]) begin
              eq <= 1'b0; cmp_done <= 1'b1;
            end
          end
          if (idx == IW'(DIGITS - 1)) begin
            idx <= '0;
            carry <= 1'b0;
            for (int i = 0; i < W; i++) begin
              case (kind)
                bcd_pkg::KIND_ADD, bcd_pkg::KIND_SUB: begin
                  acc[i] <= (i < DIGITS) ? a[i % DIGITS] : 4'd0;
                  opx[i] <= (i < DIGITS) ? b[i % DIGITS] : 4'd0;
                end
                bcd_pkg::KIND_MUL: begin
                  // opx holds a shifted to digit position pos
                  acc[i] <= 4'd0;
                  opx[i] <= (i < DIGITS) ? a[i % DIGITS] : 4'd0;
                end
                bcd_pkg::KIND_DIV: begin
                  acc[i] <= (i < DIGITS) ? a[i % DIGITS] : 4'd0;
                  opx[i] <= (i >= DIGITS - 1 && i < W - 1) ?
                            b[(i - DIGITS + 1) % DIGITS] : 4'd0;
                end
                default: begin
                  acc[i] <= 4'd0;
                  opx[i] <= 4'd0;
                end
              endcase
            end
            pos <= (kind == bcd_pkg::KIND_DIV) ? AW'(DIGITS - 1) : '0;
            cnt <= 4'd0;
            case (kind)
              bcd_pkg::KIND_ADD: state <= S_ADD;
              bcd_pkg::KIND_SUB: state <= S_ADD;
              bcd_pkg::KIND_MUL: state <= S_MCHK;
              bcd_pkg::KIND_DIV: state <= bzero ? S_FIN : S_DTRY;
              default: state <= S_FIN;
            endcase
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_ADD: begin
          // digit add/subtract over the low DIGITS digits
          acc[idx] <= add_s;
          carry <= add_co;
          if (idx == IW'(DIGITS - 1)) begin
            if (kind == bcd_pkg::KIND_ADD && add_co) status <= bcd_pkg::ST_CARRY;
            if (kind == bcd_pkg::KIND_SUB && lt) status <= bcd_pkg::ST_UNDER;
            state <= S_FIN;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MCHK: begin
          idx <= '0;
          carry <= 1'b0;
          if (cnt == b[pos]) begin
            cnt <= 4'd0;
            if (pos == AW'(DIGITS - 1)) begin
              if (mul_hi) status <= bcd_pkg::ST_CARRY;
              state <= S_FIN;
            end else begin
              pos <= pos + 1'b1;
              for (int i = W - 1; i > 0; i--) opx[i] <= opx[i-1];
              opx[0] <= 4'd0;
            end
          end else begin
            state <= S_MADD;
          end
        end
        S_MADD: begin
          acc[idx] <= add_s;
          carry <= add_co;
          if (idx == IW'(W - 1)) begin
            cnt <= cnt + 1'b1;
            state <= S_MCHK;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DTRY: begin
          // trial subtract of shifted divisor from remainder
          tmp[idx] <= add_s;
          carry <= (idx == IW'(W - 1)) ? 1'b0 : add_co;
          if (idx == IW'(W - 1)) begin
            idx <= '0;
            if (!add_co) begin
              for (int i = 0; i < W; i++)
                acc[i] <= (i == W - 1) ? add_s : tmp[i];
              cnt <= cnt + 1'b1;
            end else begin
              state <= S_DNXT;
            end
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_DNXT: begin
          q[pos] <= cnt;
          cnt <= 4'd0;
          if (pos == '0) begin
            state <= S_FIN;
          end else begin
            pos <= pos - 1'b1;
            for (int i = 0; i < W - 1; i++) opx[i] <= opx[i+1];
            opx[W-1] <= 4'd0;
            state <= S_DTRY;
          end
        end
        S_FIN: begin
          for (int i = 0; i < 16; i++) begin
            if (i < DIGITS) begin
              case (kind)
                bcd_pkg::KIND_ADD: out_data.result_value[4*i +: 4] <= acc[i % W];
                bcd_pkg::KIND_MUL: out_data.result_value[4*i +: 4] <= acc[i % W];
                bcd_pkg::KIND_SUB:
                  out_data.result_value[4*i +: 4] <= lt ? 4'd0 : acc[i % W];
                bcd_pkg::KIND_DIV: out_data.result_value[4*i +: 4] <= q[i % DIGITS];
                default: out_data.result_value[4*i +: 4] <= 4'd0;
              endcase
            end else begin
              out_data.result_value[4*i +: 4] <= 4'd0;
            end
          end
          out_data.status <= (kind == bcd_pkg::KIND_DIV && bzero) ?
                             bcd_pkg::ST_DIVZ : status;
          out_data.a_less_b  <= lt;
          out_data.a_equal_b <= eq;
          state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_data.a_less_b && out_data.a_equal_b))
    else $error("less and equal both set");
  assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("accepted while busy");
endmodule

>>> design/bcd_adder.sv
// shared single-digit decimal adder/subtracter, used one digit per sequencer step
`timescale 1ns / 1ps
module bcd_adder (
  input  logic [3:0] x,
  input  logic [3:0] y,
  input  logic       sub,
  input  logic       cin,
  output logic [3:0] sum,
  output logic       cout
);
  logic [4:0] s;
  logic [4:0] t;
  always_comb begin
    s = 5'd0;
    t = 5'd0;
    cout = 1'b0;
    if (sub) begin
      t = 5'd10 + {1'b0, x} - {4'd0, cin} - {1'b0, y};
      if (t >= 5'd10) begin
        sum = 4'(t - 5'd10);
        cout = 1'b0;
      end else begin
        sum = t[3:0];
        cout = 1'b1;
      end
    end else begin
      s = {1'b0, x} + {1'b0, y} + {4'd0, cin};
      if (s > 5'd9) begin
        sum = 4'(s - 5'd10);
        cout = 1'b1;
      end else begin
        sum = s[3:0];
      end
    end
  end
endmodule

>>> tb/bcd_decimal_alu_test.sv
// testbench for the decimal alu: directed and random transactions checked by a scoreboard
`timescale 1ns / 1ps
module bcd_decimal_alu_test;

  localparam bit [127:0] DEC_LIMIT = 128'd10000000000000000;
  localparam int WATCH_LIMIT = 40000;
  localparam int RANDOM_ITEMS = 880;

  class alu_scoreboard;
    bcd_pkg::out_item_t pending_results[$];
    int errors;
    int checked;

    function bit [127:0] bcd_to_bin(logic [63:0] v);
      bit [127:0] x;
      bit [3:0] n;
      x = 0;
      for (int i = 15; i >= 0; i--) begin
        n = v[4*i +: 4];
        x = x * 10 + ((n > 9) ? 4'd9 : n);
      end
      return x;
    endfunction

    function logic [63:0] bin_to_bcd(bit [127:0] x);
      logic [63:0] v;
      v = '0;
      for (int i = 0; i < 16; i++) begin
        v[4*i +: 4] = 4'(x % 10);
        x = x / 10;
      end
      return v;
    endfunction

    function bcd_pkg::out_item_t compute_result(bcd_pkg::in_item_t t);
      bcd_pkg::out_item_t r;
      bit [127:0] a, b, v;
      a = bcd_to_bin(t.operand_a);
      b = bcd_to_bin(t.operand_b);
      v = 0;
      r.status = bcd_pkg::ST_OK;
      r.a_less_b = (a < b);
      r.a_equal_b = (a == b);
      case (t.kind)
        bcd_pkg::KIND_ADD: begin
          v = a + b;
          if (v >= DEC_LIMIT) begin
            r.status = bcd_pkg::ST_CARRY;
            v = v - DEC_LIMIT;
          end
        end
        bcd_pkg::KIND_SUB: begin
          if (a < b) r.status = bcd_pkg::ST_UNDER;
          else v = a - b;
        end
        bcd_pkg::KIND_MUL: begin
          v = a * b;
          if (v >= DEC_LIMIT) begin
            r.status = bcd_pkg::ST_CARRY;
            v = v % DEC_LIMIT;
          end
        end
        bcd_pkg::KIND_DIV: begin
          if (b == 0) r.status = bcd_pkg::ST_DIVZ;
          else v = a / b;
        end
        default: v = 0;
      endcase
      r.result_value = bin_to_bcd(v);
      return r;
    endfunction

    function void note_input(bcd_pkg::in_item_t t);
      pending_results.push_back(compute_result(t));
    endfunction

    task report(string what, logic [63:0] got, logic [63:0] want);
      $display("mismatch %s: got %h want %h (result %0d)", what, got, want, checked);
      errors++;
    endtask

    task check_result(bcd_pkg::out_item_t r);
      bcd_pkg::out_item_t e;
      if (pending_results.size() == 0) begin
        report("unexpected transaction", r.result_value, 64'd0);
        return;
      end
      e = pending_results.pop_front();
      if (r.result_value !== e.result_value) report("result_value", r.result_value, e.result_value);
      if (r.a_less_b !== e.a_less_b)
        report("a_less_b", 64'(r.a_less_b), 64'(e.a_less_b));
      if (r.a_equal_b !== e.a_equal_b)
        report("a_equal_b", 64'(r.a_equal_b), 64'(e.a_equal_b));
      if (r.status !== e.status) report("status", 64'(r.status), 64'(e.status));
      checked++;
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_ready;
  bcd_pkg::in_item_t in_data = '0;
  logic out_valid;
  logic out_ready = 0;
  bcd_pkg::out_item_t out_data;

  alu_scoreboard sb = new();
  int sent;
  int idle_cycles;
  bit long_hold_done;

  always #10 clk = ~clk;

  bcd_decimal_alu uut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data)
  );

  function logic [63:0] rand_operand();
    logic [63:0] v;
    int mode, n;
    v = '0;
    mode = $urandom_range(0, 9);
    if (mode == 0) begin
      v = {$urandom(), $urandom()};
    end else begin
      n = (mode < 7) ? $urandom_range(1, 6) : $urandom_range(1, 16);
      for (int i = 0; i < n; i++) v[4*i +: 4] = 4'($urandom_range(0, 9));
    end
    return v;
  endfunction

  function int draw_gap(int count);
    if ((count / 100) % 3 == 0) return 0;
    return $urandom_range(0, 16);
  endfunction

  task send_item(logic [2:0] kind, logic [63:0] a, logic [63:0] b);
    int gap;
    gap = draw_gap(sent);
    @(negedge clk);
    if (gap > 0) begin
      in_valid = 0;
      repeat (gap) @(negedge clk);
    end
    in_data.kind = kind;
    in_data.operand_a = a;
    in_data.operand_b = b;
    in_valid = 1;
    // in_ready only moves at a rising edge
    while (!in_ready) @(negedge clk);
    @(posedge clk);
    sb.note_input(in_data);
    sent++;
  endtask

  task wait_drained();
    while (sb.pending_results.size() != 0) @(posedge clk);
  endtask

  // watchdog on stalled handshakes
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCH_LIMIT) begin
      $display("timeout after %0d idle cycles", idle_cycles);
      $display("TB_ERROR");
      $finish;
    end
  end

  // receiver
  initial begin
    int gap;
    wait (!rst);
    forever begin
      gap = draw_gap(sb.checked);
      if (!long_hold_done && sb.checked == 300) begin
        gap = 400;
        long_hold_done = 1;
      end
      @(negedge clk);
      if (gap > 0) begin
        out_ready = 0;
        repeat (gap) @(negedge clk);
      end
      out_ready = 1;
      while (!out_valid) @(negedge clk);
      @(posedge clk);
      sb.check_result(out_data);
    end
  end

  initial begin
    logic [63:0] nines;
    logic [2:0] k;
    nines = 64'h9999_9999_9999_9999;
    repeat (4) @(negedge clk);
    rst = 0;

    send_item(bcd_pkg::KIND_ADD, 64'd0, 64'd0);
    send_item(bcd_pkg::KIND_ADD, nines, 64'h1);
    send_item(bcd_pkg::KIND_ADD, nines, nines);
    send_item(bcd_pkg::KIND_SUB, nines, nines);
    send_item(bcd_pkg::KIND_SUB, 64'h5, 64'h6);
    send_item(bcd_pkg::KIND_SUB, 64'h1000, 64'h1);
    send_item(bcd_pkg::KIND_MUL, nines, nines);
    send_item(bcd_pkg::KIND_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
    send_item(bcd_pkg::KIND_MUL, 64'h1234, 64'd0);
    send_item(bcd_pkg::KIND_DIV, nines, 64'h7);
    send_item(bcd_pkg::KIND_DIV, 64'h42, 64'd0);
    send_item(bcd_pkg::KIND_DIV, 64'h3, nines);
    send_item(bcd_pkg::KIND_CMP, 64'h12, 64'h12);
    send_item(bcd_pkg::KIND_CMP, 64'h11, 64'h12);
    send_item(bcd_pkg::KIND_CMP, '1, nines);
    send_item(bcd_pkg::KIND_ADD, '1, '1);
    send_item(bcd_pkg::KIND_DIV, 64'h00AB, 64'h000F);
    send_item(3'd5, 64'h7, 64'h8);
    send_item(3'd6, 64'h9, 64'h8);
    send_item(3'd7, '1, 64'd0);

    // pause until the block is empty
    @(negedge clk);
    in_valid = 0;
    wait_drained();

    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      k = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7)) : 3'($urandom_range(0, 4));
      send_item(k, rand_operand(), ($urandom_range(0, 9) == 0) ? rand_operand() & 64'hF
                                                               : rand_operand());
    end
    @(negedge clk);
    in_valid = 0;

    wait_drained();
    repeat (200) @(posedge clk);
    $display("covered %0d transactions: all operations, carry, underflow, divide by zero,",
             sent);
    $display("non-decimal digits and unused operation codes, with random stalls on both sides");
    if (sb.errors == 0 && sb.pending_results.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("%0d mismatches, %0d results missing", sb.errors, sb.pending_results.size());
      $display("TB_ERROR");
    end
    $finish;
  end
endmodule
